### sv/kqh_pkg.sv
`default_nettype none

package kqh_pkg;

   localparam int HYST_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int NV_RESET  = 16;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_VALUES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HYSTERESIS = 2'd1;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_STEP_GO  = 8'b0000_0010,
      S_STEP_WT  = 8'b0000_0100,
      S_IDX_GO   = 8'b0000_1000,
      S_IDX_WT   = 8'b0001_0000,
      S_BASE     = 8'b0010_0000,
      S_BAND     = 8'b0100_0000,
      S_EMIT     = 8'b1000_0000
   } kqh_state_type;

   typedef struct packed {
      logic latch_sample;
      logic load_cfg;
      logic div_start;
      logic div_sel_step;
      logic load_step;
      logic load_index;
      logic load_base;
      logic load_band;
      logic load_rsp;
   } kqh_cmd_type;

   typedef struct packed {
      logic outside;
      logic div_done;
   } kqh_status_type;

endpackage

`default_nettype wire

### sv/knob_quantizer_hysteresis.sv
// Sample path: one inside the current band goes straight to the emit state and result
//    register; one outside passes index division, base, band (DIV_W = 11 by default).
// One sample at a time, taken in idle; the shared one-bit-per-cycle divider paces it.
// Register write: step and index division, base and band; both channels stall meanwhile.
// Reset: synchronous, active high; 16 positions, no hysteresis, index 0, sample 0.
`default_nettype none

module knob_quantizer_hysteresis
   import kqh_pkg::*;
#(
   parameter int SAMPLE_BITS   = 10,
   parameter int MAX_POSITIONS = 256,
   localparam int NV_W  = ($clog2(MAX_POSITIONS + 1) > 5) ? $clog2(MAX_POSITIONS + 1) : 5,
   localparam int IDX_W = ($clog2(MAX_POSITIONS) > 4) ? $clog2(MAX_POSITIONS) : 4,
   localparam int CSR_W = (NV_W > HYST_W) ? NV_W : HYST_W
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_W-1:0]       csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [IDX_W-1:0]            rsp_index,
   output logic                        rsp_changed
);

   kqh_cmd_type    cmd;
   kqh_status_type status;

   kqh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   kqh_datapath #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .MAX_POSITIONS (MAX_POSITIONS),
      .NV_W          (NV_W),
      .IDX_W         (IDX_W),
      .CSR_W         (CSR_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_sample  (req_sample),
      .rsp_index   (rsp_index),
      .rsp_changed (rsp_changed)
   );

   a_no_dual_accept: assert property (@(posedge clock) disable iff (reset)
      !(csr_valid && csr_ready && req_valid && req_ready))
      else $error("register write and sample taken in the same cycle");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !csr_ready))
      else $error("channels not stalled while a sample is processed");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   a_div_not_restarted: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !cmd.div_start)
      else $error("divider restarted while running");

endmodule

`default_nettype wire

### sv/kqh_divider.sv
`default_nettype none

module kqh_divider #(
   parameter int W = 11
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  div_ff, div_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;
   logic          ge;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign ge      = (shifted >= {1'b0, div_ff});
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### sv/kqh_datapath.sv
`default_nettype none

module kqh_datapath
   import kqh_pkg::*;
#(
   parameter int SAMPLE_BITS   = 10,
   parameter int MAX_POSITIONS = 256,
   parameter int NV_W          = 9,
   parameter int IDX_W         = 8,
   parameter int CSR_W         = 9
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kqh_cmd_type            cmd,
   output kqh_status_type              status,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_W-1:0]       csr_wdata,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   output logic [IDX_W-1:0]            rsp_index,
   output logic                        rsp_changed
);

   localparam int SB         = SAMPLE_BITS;
   localparam int STEP_W     = SB + 1;
   localparam int DIV_W      = (STEP_W > NV_W) ? STEP_W : NV_W;
   localparam int FULL       = 1 << SB;
   localparam int STEP_RESET = FULL / NV_RESET;
   localparam logic [SB-1:0] TOP = SB'(FULL - 1);

   logic [NV_W-1:0]   num_ff, num_in;
   logic [HYST_W-1:0] hyst_ff, hyst_in;
   logic [SB-1:0]     last_ff, last_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [HYST_W-1:0] eff_ff, eff_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic              moved_ff, moved_in;
   logic [SB-1:0]     base_ff, base_in;
   logic [SB-1:0]     low_ff, low_in;
   logic [SB-1:0]     high_ff, high_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_changed_ff, rsp_changed_in;

   logic [DIV_W-1:0]        div_dividend;
   logic [DIV_W-1:0]        div_divisor;
   logic                    div_done;
   logic [DIV_W-1:0]        div_q;
   logic [NV_W-1:0]         wr_num;
   logic [NV_W-1:0]         top_idx;
   logic [STEP_W-1:0]       step_new;
   logic [SB-1:0]           half;
   logic [IDX_W-1:0]        idx_new;
   logic [IDX_W+STEP_W-1:0] prod;
   logic [SB+1:0]           high_sum;

   assign div_dividend = cmd.div_sel_step ? DIV_W'(FULL) : DIV_W'(last_ff);
   assign div_divisor  = cmd.div_sel_step ? DIV_W'(num_ff) : DIV_W'(step_ff);

   kqh_divider #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign status.div_done = div_done;
   assign status.outside  = (req_sample < low_ff) || (req_sample > high_ff);

   always_comb begin
      wr_num = csr_wdata[NV_W-1:0];
      if (wr_num == '0)
         wr_num = NV_W'(1);
      else if (wr_num > NV_W'(MAX_POSITIONS))
         wr_num = NV_W'(MAX_POSITIONS);
   end

   assign top_idx  = num_ff - NV_W'(1);
   assign step_new = (div_q[STEP_W-1:0] == '0) ? STEP_W'(1) : div_q[STEP_W-1:0];
   assign half     = step_new[STEP_W-1:1];
   assign idx_new  = (div_q > DIV_W'(top_idx)) ? IDX_W'(top_idx) : IDX_W'(div_q);
   assign prod     = cur_ff * step_ff;
   assign high_sum = (SB+2)'(base_ff) + (SB+2)'(step_ff) + (SB+2)'(eff_ff);

   always_comb begin
      num_in         = num_ff;
      hyst_in        = hyst_ff;
      last_in        = last_ff;
      step_in        = step_ff;
      eff_in         = eff_ff;
      cur_in         = cur_ff;
      moved_in       = moved_ff;
      base_in        = base_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_changed_in = rsp_changed_ff;

      if (cmd.load_cfg) begin
         case (csr_index)
            REG_NUM_VALUES: num_in  = wr_num;
            REG_HYSTERESIS: hyst_in = csr_wdata[HYST_W-1:0];
            default: ;
         endcase
      end
      if (cmd.latch_sample) begin
         last_in  = req_sample;
         moved_in = 1'b0;
      end
      if (cmd.load_step) begin
         step_in = step_new;
         eff_in  = (SB'(hyst_ff) > half) ? half[HYST_W-1:0] : hyst_ff;
      end
      if (cmd.load_index) begin
         cur_in   = idx_new;
         moved_in = (idx_new != cur_ff);
      end
      if (cmd.load_base)
         base_in = prod[SB-1:0];
      if (cmd.load_band) begin
         low_in = (cur_ff == '0) ? '0 : base_ff - SB'(eff_ff);
         if (cur_ff == IDX_W'(top_idx))
            high_in = TOP;
         else
            high_in = (high_sum > (SB+2)'(TOP)) ? TOP : high_sum[SB-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_index_in   = cur_ff;
         rsp_changed_in = moved_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff   <= NV_W'(NV_RESET);
         hyst_ff  <= '0;
         last_ff  <= '0;
         step_ff  <= STEP_W'(STEP_RESET);
         eff_ff   <= '0;
         cur_ff   <= '0;
         moved_ff <= 1'b0;
         low_ff   <= '0;
         high_ff  <= SB'(STEP_RESET);
      end else begin
         num_ff   <= num_in;
         hyst_ff  <= hyst_in;
         last_ff  <= last_in;
         step_ff  <= step_in;
         eff_ff   <= eff_in;
         cur_ff   <= cur_in;
         moved_ff <= moved_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
      base_ff        <= base_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_index   = rsp_index_ff;
   assign rsp_changed = rsp_changed_ff;

endmodule

`default_nettype wire

### sv/kqh_ctrl.sv
`default_nettype none

module kqh_ctrl
   import kqh_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output kqh_cmd_type               cmd,
   input  wire kqh_status_type       status
);

   kqh_state_type state_ff, state_in;
   logic          item_ff, item_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      csr_ready    = (state_ff == S_IDLE);
      req_ready    = (state_ff == S_IDLE) && !csr_valid;

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index inside {REG_NUM_VALUES, REG_HYSTERESIS}) begin
                  item_in      = 1'b0;
                  cmd.load_cfg = 1'b1;
                  state_in     = S_STEP_GO;
               end
            end else if (req_valid) begin
               item_in          = 1'b1;
               cmd.latch_sample = 1'b1;
               state_in         = status.outside ? S_IDX_GO : S_EMIT;
            end
         end
         S_STEP_GO: begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_step = 1'b1;
            state_in         = S_STEP_WT;
         end
         S_STEP_WT: begin
            if (status.div_done) begin
               cmd.load_step = 1'b1;
               state_in      = S_IDX_GO;
            end
         end
         S_IDX_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_IDX_WT;
         end
         S_IDX_WT: begin
            if (status.div_done) begin
               cmd.load_index = 1'b1;
               state_in       = S_BASE;
            end
         end
         S_BASE: begin
            cmd.load_base = 1'b1;
            state_in      = S_BAND;
         end
         S_BAND: begin
            cmd.load_band = 1'b1;
            state_in      = item_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         item_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         item_ff      <= item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
